// ----- hw/rtl/note_queue_tone_sequencer_assert.svh -----
// Assertion macros used by the checker of the tone sequencer.
`ifndef NOTE_QUEUE_TONE_SEQUENCER_ASSERT_SVH
`define NOTE_QUEUE_TONE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define NQTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nqts check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define NQTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nqts check failed");

`endif

// ----- hw/rtl/nqts_pkg.sv -----
package nqts_pkg;

  // Request codes on req_type_i
  localparam logic [1:0] REQ_PLAY  = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_RESET = 2'd2;

  // Register indexes on the config port
  localparam logic [1:0] REG_LOW  = 2'd0;
  localparam logic [1:0] REG_HIGH = 2'd1;
  localparam logic [1:0] REG_STEP = 2'd2;

  localparam logic [15:0] WRAP_LOW_RST  = 16'd200;
  localparam logic [15:0] WRAP_HIGH_RST = 16'd1200;
  localparam logic [15:0] WRAP_STEP_RST = 16'd1000;

  // x/20 = ((x>>2) * 52429) >> 18, exact for 14-bit x>>2
  localparam logic [16:0] DIV5_MUL = 17'd52429;

  localparam logic signed [20:0] FREQ_MAX = 21'sd131071;
  localparam logic signed [20:0] FREQ_MIN = -21'sd131072;

  typedef enum logic [1:0] {
    CMD_PLAY,
    CMD_TICK,
    CMD_RESET,
    CMD_BAD
  } cmd_kind_e;

  typedef struct packed {
    logic [15:0]        freq;
    logic [11:0]        ticks;
    logic signed [11:0] slide;
  } note_t;

  typedef struct packed {
    cmd_kind_e kind;
    logic [3:0] chan;
    note_t      note;
  } cmd_t;

  typedef struct packed {
    logic [15:0] low;
    logic [15:0] high;
    logic [15:0] step;
  } cfg_t;

  typedef struct packed {
    logic [3:0]         chan;
    logic               freq_write;
    logic signed [17:0] tone;
    logic [6:0]         pending;
    logic               status;
    logic               dropped;
    logic               last;
  } res_t;

endpackage

// ----- hw/rtl/nqts_ram.sv -----
module nqts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/nqts_fifo.sv -----
module nqts_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Pointer and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hw/rtl/nqts_front.sv -----
module nqts_front #(
  parameter int NumChannels = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          req_type_i,
  input  logic [3:0]          chan_sel_i,
  input  logic [15:0]         note_freq_i,
  input  logic [15:0]         duration_ms_i,
  input  logic signed [15:0]  slide_rate_i,
  output nqts_pkg::cmd_t      cmd_o,
  output logic                cmd_valid_o,
  input  logic                cmd_pop_i
);
  import nqts_pkg::*;

  cmd_t        cmd;
  logic        slide_neg;
  logic [15:0] slide_mag;
  logic [30:0] slide_prod;
  logic [29:0] dur_prod;
  logic [10:0] slide_q20;
  logic [10:0] slide_fix;
  logic        cmd_empty;
  logic        enq;

  // Divide slide magnitude and duration by 20
  assign slide_neg  = slide_rate_i[15];
  assign slide_mag  = slide_neg ? 16'(-slide_rate_i) : slide_rate_i;
  assign slide_prod = 31'(slide_mag[15:2]) * 31'(DIV5_MUL);
  assign dur_prod   = 30'(duration_ms_i[15:2]) * 30'(DIV5_MUL);
  assign slide_q20  = slide_prod[28:18];
  assign slide_fix  = ((slide_mag != '0) && (slide_q20 == '0)) ? 11'd1 : slide_q20;

  // Classify
  always_comb begin
    cmd.chan       = chan_sel_i;
    cmd.note.freq  = note_freq_i;
    cmd.note.ticks = dur_prod[29:18];
    cmd.note.slide = slide_neg ? -$signed({1'b0, slide_fix}) : $signed({1'b0, slide_fix});
    case (req_type_i)
      REQ_PLAY:  cmd.kind = (chan_sel_i >= 4'(NumChannels)) ? CMD_BAD : CMD_PLAY;
      REQ_RESET: cmd.kind = (chan_sel_i >= 4'(NumChannels)) ? CMD_BAD : CMD_RESET;
      REQ_TICK:  cmd.kind = CMD_TICK;
      default:   cmd.kind = CMD_TICK;
    endcase
  end

  // Unused request code is taken and dropped
  assign enq = push && !full && (req_type_i == REQ_PLAY || req_type_i == REQ_TICK ||
                                 req_type_i == REQ_RESET);

  nqts_fifo #(
    .Width($bits(cmd_t)),
    .Depth(2)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (enq),
    .wdata_i(cmd),
    .full_o (full),
    .pop_i  (cmd_pop_i),
    .rdata_o(cmd_o),
    .empty_o(cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

// ----- hw/rtl/nqts_back.sv -----
module nqts_back #(
  parameter int NumChannels = 4,
  parameter int QueueDepth  = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  nqts_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  nqts_pkg::cfg_t cfg_i,
  output nqts_pkg::res_t res_o,
  output logic           res_push_o,
  input  logic           res_full_i
);
  import nqts_pkg::*;

  localparam int ChW  = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  localparam int HdW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam int RamD = NumChannels * QueueDepth;
  localparam int AW   = (RamD > 1) ? $clog2(RamD) : 1;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_TICK_RD = 2'd1;
  localparam logic [1:0] ST_TICK_EX = 2'd2;

  logic [1:0]     state_q, state_d;
  logic [ChW-1:0] tch_q, tch_d;

  logic                playing_q [NumChannels];
  logic                playing_d [NumChannels];
  logic [11:0]         ticks_q   [NumChannels];
  logic [11:0]         ticks_d   [NumChannels];
  logic signed [17:0]  freq_q    [NumChannels];
  logic signed [17:0]  freq_d    [NumChannels];
  logic signed [11:0]  slide_q   [NumChannels];
  logic signed [11:0]  slide_d   [NumChannels];
  logic [CntW-1:0]     count_q   [NumChannels];
  logic [CntW-1:0]     count_d   [NumChannels];
  logic [HdW-1:0]      head_q    [NumChannels];
  logic [HdW-1:0]      head_d    [NumChannels];

  logic [ChW-1:0]     ch;
  logic [CntW:0]      tail_sum;
  logic [HdW-1:0]     tail;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic               ram_we, ram_re;
  note_t              ram_rdata;
  logic signed [20:0] lo_s, hi_s, st_s, f0, f1, f2, fsat;

  // Channel in focus: command channel when idle, tick counter otherwise
  assign ch = (state_q == ST_IDLE) ? cmd_i.chan[ChW-1:0] : tch_q;

  // Queue tail slot of the channel
  assign tail_sum  = (CntW + 1)'(head_q[ch]) + (CntW + 1)'(count_q[ch]);
  assign tail      = (tail_sum >= (CntW + 1)'(QueueDepth)) ?
                     HdW'(tail_sum - (CntW + 1)'(QueueDepth)) : HdW'(tail_sum);
  assign ram_waddr = AW'(32'(ch) * QueueDepth + 32'(tail));
  assign ram_raddr = AW'(32'(ch) * QueueDepth + 32'(head_q[ch]));

  // Slide and wrap of the current frequency
  assign lo_s = $signed({5'b0, cfg_i.low});
  assign hi_s = $signed({5'b0, cfg_i.high});
  assign st_s = $signed({5'b0, cfg_i.step});
  assign f0   = 21'(freq_q[ch]) + 21'(slide_q[ch]);
  assign f1   = (f0 < lo_s) ? f0 + st_s : f0;
  assign f2   = (f1 > hi_s) ? f1 - st_s : f1;
  assign fsat = (f2 > FREQ_MAX) ? FREQ_MAX : ((f2 < FREQ_MIN) ? FREQ_MIN : f2);

  nqts_ram #(
    .Width($bits(note_t)),
    .Depth(RamD)
  ) u_note_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(cmd_i.note),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Command execution
  always_comb begin
    state_d    = state_q;
    tch_d      = tch_q;
    playing_d  = playing_q;
    ticks_d    = ticks_q;
    freq_d     = freq_q;
    slide_d    = slide_q;
    count_d    = count_q;
    head_d     = head_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    res_o.chan = 4'(ch);

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          case (cmd_i.kind)
            CMD_PLAY: begin
              cmd_pop_o  = 1'b1;
              res_push_o = 1'b1;
              res_o.last = 1'b1;
              if (!playing_q[ch]) begin
                // Idle channel has an empty queue: start this note directly
                playing_d[ch]    = 1'b1;
                freq_d[ch]       = $signed({2'b0, cmd_i.note.freq});
                ticks_d[ch]      = cmd_i.note.ticks;
                slide_d[ch]      = cmd_i.note.slide;
                res_o.freq_write = 1'b1;
                res_o.tone       = $signed({2'b0, cmd_i.note.freq});
                res_o.pending    = 7'd1;
              end else if (count_q[ch] < CntW'(QueueDepth)) begin
                ram_we        = 1'b1;
                count_d[ch]   = count_q[ch] + 1'b1;
                res_o.pending = 7'(count_q[ch]) + 7'd2;
              end else begin
                res_o.dropped = 1'b1;
                res_o.pending = 7'(count_q[ch]) + 7'd1;
              end
            end
            CMD_RESET: begin
              cmd_pop_o        = 1'b1;
              res_push_o       = 1'b1;
              playing_d[ch]    = 1'b0;
              ticks_d[ch]      = '0;
              count_d[ch]      = '0;
              res_o.freq_write = 1'b1;
              res_o.last       = 1'b1;
            end
            CMD_BAD: begin
              cmd_pop_o    = 1'b1;
              res_push_o   = 1'b1;
              res_o.chan   = cmd_i.chan;
              res_o.status = 1'b1;
              res_o.last   = 1'b1;
            end
            default: begin
              tch_d   = '0;
              state_d = ST_TICK_RD;
            end
          endcase
        end
      end

      ST_TICK_RD: begin
        ram_re  = 1'b1;
        state_d = ST_TICK_EX;
      end

      ST_TICK_EX: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (playing_q[ch]) begin
            if (ticks_q[ch] == '0) begin
              // Note over: start the head note if one waits
              res_o.freq_write = 1'b1;
              playing_d[ch]    = 1'b0;
              if (count_q[ch] != '0) begin
                playing_d[ch] = 1'b1;
                freq_d[ch]    = $signed({2'b0, ram_rdata.freq});
                ticks_d[ch]   = ram_rdata.ticks;
                slide_d[ch]   = ram_rdata.slide;
                count_d[ch]   = count_q[ch] - 1'b1;
                head_d[ch]    = (head_q[ch] == HdW'(QueueDepth - 1)) ? '0 :
                                head_q[ch] + 1'b1;
                res_o.tone    = $signed({2'b0, ram_rdata.freq});
              end
            end else begin
              ticks_d[ch] = ticks_q[ch] - 1'b1;
              if (slide_q[ch] != '0) begin
                freq_d[ch]       = 18'(fsat);
                res_o.freq_write = 1'b1;
                res_o.tone       = 18'(fsat);
              end
            end
          end
          res_o.pending = 7'(count_d[ch]) + 7'(playing_d[ch]);
          if (tch_q == ChW'(NumChannels - 1)) begin
            res_o.last = 1'b1;
            cmd_pop_o  = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            tch_d   = tch_q + 1'b1;
            state_d = ST_TICK_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tch_q   <= '0;
      for (int i = 0; i < NumChannels; i++) begin
        playing_q[i] <= 1'b0;
        ticks_q[i]   <= '0;
        freq_q[i]    <= '0;
        slide_q[i]   <= '0;
        count_q[i]   <= '0;
        head_q[i]    <= '0;
      end
    end else begin
      state_q   <= state_d;
      tch_q     <= tch_d;
      playing_q <= playing_d;
      ticks_q   <= ticks_d;
      freq_q    <= freq_d;
      slide_q   <= slide_d;
      count_q   <= count_d;
      head_q    <= head_d;
    end
  end

endmodule

// ----- hw/rtl/note_queue_tone_sequencer.sv -----
// Per-channel note sequencer with a note queue per channel.
// Requests enter through push/full: a play word queues a note on a channel,
// a reset word silences and empties one channel, a tick word advances all
// channels by one 50 Hz step. Results leave through empty/pop, oldest first.
// Play, reset and bad-channel words give one result; a tick gives one
// result per channel, the last one flagged by last_result_o.
// A play, reset or bad-channel result passes the request queue and the result
// queue before it can be popped; such words run one per cycle while no tick
// is in progress and the result queue has room. A tick runs a dispatch step,
// then per channel a note memory read and an update, the update waiting while
// the result queue is full; the registered note memory read port needs the read.
// A two-entry request queue lets words be pushed while the back end works,
// and a two-entry result queue decouples it from the consumer. When pop is
// held low the back end stops once the result queue holds two words, and the
// request queue fills, raising full. Reset clears all channels to silent and
// empty and loads the wrap registers with 200, 1200 and 1000. Registers are
// written on the APB port at byte addresses 0, 4 and 8, and read back there.
module note_queue_tone_sequencer #(
  parameter int NUM_CHANNELS = 4,
  parameter int QUEUE_DEPTH  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         req_type_i,
  input  logic [3:0]         chan_sel_i,
  input  logic [15:0]        note_freq_i,
  input  logic [15:0]        duration_ms_i,
  input  logic signed [15:0] slide_rate_i,
  output logic               empty,
  input  logic               pop,
  output logic [3:0]         out_chan_o,
  output logic               freq_write_o,
  output logic signed [17:0] tone_freq_o,
  output logic [6:0]         pending_notes_o,
  output logic               status_code_o,
  output logic               note_dropped_o,
  output logic               last_result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import nqts_pkg::*;

  cfg_t cfg_q, cfg_d;
  cmd_t cmd;
  res_t res, res_out;
  logic cmd_valid, cmd_pop, res_push, res_full;

  // Config registers
  assign pready = 1'b1;
  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_LOW:  cfg_d.low  = pwdata[15:0];
        REG_HIGH: cfg_d.high = pwdata[15:0];
        REG_STEP: cfg_d.step = pwdata[15:0];
        default:  cfg_d      = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LOW:  prdata = {16'b0, cfg_q.low};
      REG_HIGH: prdata = {16'b0, cfg_q.high};
      REG_STEP: prdata = {16'b0, cfg_q.step};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low  <= WRAP_LOW_RST;
      cfg_q.high <= WRAP_HIGH_RST;
      cfg_q.step <= WRAP_STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  nqts_front #(
    .NumChannels(NUM_CHANNELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .req_type_i   (req_type_i),
    .chan_sel_i   (chan_sel_i),
    .note_freq_i  (note_freq_i),
    .duration_ms_i(duration_ms_i),
    .slide_rate_i (slide_rate_i),
    .cmd_o        (cmd),
    .cmd_valid_o  (cmd_valid),
    .cmd_pop_i    (cmd_pop)
  );

  nqts_back #(
    .NumChannels(NUM_CHANNELS),
    .QueueDepth (QUEUE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .cfg_i      (cfg_q),
    .res_o      (res),
    .res_push_o (res_push),
    .res_full_i (res_full)
  );

  // Result queue
  nqts_fifo #(
    .Width($bits(res_t)),
    .Depth(2)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_out),
    .empty_o(empty)
  );

  assign out_chan_o      = res_out.chan;
  assign freq_write_o    = res_out.freq_write;
  assign tone_freq_o     = res_out.tone;
  assign pending_notes_o = res_out.pending;
  assign status_code_o   = res_out.status;
  assign note_dropped_o  = res_out.dropped;
  assign last_result_o   = res_out.last;

endmodule

// ----- hw/rtl/nqts_checker.sv -----
`include "note_queue_tone_sequencer_assert.svh"

module nqts_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic [3:0]         out_chan_o,
  input logic               freq_write_o,
  input logic signed [17:0] tone_freq_o,
  input logic               status_code_o,
  input logic               note_dropped_o,
  input logic               last_result_o
);

  // Bad channel word is a single, final, silent result
  `NQTS_ASSERT_IMP(a_bad_is_last, !empty && status_code_o, last_result_o && !freq_write_o)

  // No tone value without a frequency write
  `NQTS_ASSERT_IMP(a_tone_zero, !empty && !freq_write_o, tone_freq_o == 18'sd0)

  // A dropped note never carries a bad-channel status
  `NQTS_ASSERT_IMP(a_drop_ok_chan, !empty && note_dropped_o, !status_code_o && last_result_o)

  // Stalled word holds
  `NQTS_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(out_chan_o) && $stable(tone_freq_o))

endmodule

bind note_queue_tone_sequencer nqts_checker u_nqts_checker (.*);
